### hdl/capacitor_voltage_hysteresis_check_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the capacitor voltage hysteresis check
// Shared concurrent assertion forms on clock, all but one disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAPACITOR_VOLTAGE_HYSTERESIS_CHECK_MACROS_SVH
`define CAPACITOR_VOLTAGE_HYSTERESIS_CHECK_MACROS_SVH

// Same-cycle implication.
`define CVHC_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cvhc assertion failed");

// Next-cycle implication.
`define CVHC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cvhc assertion failed");

// Implication that also holds across the edge that ends reset.
`define CVHC_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) $past(reset) |-> (cons)) \
      else $error("cvhc assertion failed");

`endif

### hdl/cvhc_pkg.sv
// ----------------------------------------------------------------------------
// cvhc_pkg
// Types and constants shared by the capacitor voltage hysteresis check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cvhc_pkg;

   localparam int SAMPLE_W = 12;
   localparam int COEF_W   = 12;
   localparam int MV_W     = 16;
   localparam int WAITS_W  = 8;
   localparam int PROD_W   = SAMPLE_W + COEF_W;

   // floor(p / 500) = floor((p >> 2) / 125); the divide by 125 is a multiply
   // by ceil(2^29 / 125) and a shift, exact for dividends p >> 2 below 2^22.
   localparam int        QUOT_IN_W = PROD_W - 2;
   localparam int        RECIP_W   = 23;
   localparam int        DIV_SHIFT = 29;
   localparam int        DIV_PROD_W = QUOT_IN_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 23'd4294968;

   localparam logic [MV_W-1:0] VOLTAGE_MAX = 16'd33538;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEAS_COEF      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WAITS      = 2'd3;

   localparam logic [COEF_W-1:0]  MEAS_COEF_RESET = 12'd812;
   localparam logic [MV_W-1:0]    LOW_RESET       = 16'd0;
   localparam logic [MV_W-1:0]    HIGH_RESET      = 16'd0;
   localparam logic [WAITS_W-1:0] MAX_WAITS_RESET = 8'd10;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_WAITING   = 2'd1,
      STATUS_RECOVERED = 2'd2,
      STATUS_TIMEOUT   = 2'd3
   } status_type;

   typedef enum logic {
      HYST_IDLE = 1'b0,
      HYST_WAIT = 1'b1
   } hyst_state_type;

   typedef struct packed {
      logic [MV_W-1:0]    low_mv;
      logic [MV_W-1:0]    high_mv;
      logic [WAITS_W-1:0] max_waits;
   } hyst_cfg_type;

   typedef struct packed {
      logic          push;
      logic          full;
      logic          pop;
      logic          empty;
   } queue_ctl_type;

endpackage

`default_nettype wire

### hdl/capacitor_voltage_hysteresis_check.sv
// ----------------------------------------------------------------------------
// capacitor_voltage_hysteresis_check
// Storage capacitor voltage measurement with hysteresis on camera power.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive five raw ADC samples with push; a transfer takes place
//   at a rising edge with push high and full low. One item per cycle is
//   taken in steady state while the result side keeps popping.
//   Result queue: while empty is low the oldest result (voltage_mv, status,
//   power_off) sits on the rsp_ ports; pop high at an edge transfers it.
//   Path: an input passes three front stages into the queue, then one back
//   stage into the result register.
//   Throughput: one item per cycle while pop keeps up, set by the front
//   pipeline and the single result register, which refills as it is popped.
//   Stall: while pop stays low the result holds, the four-entry middle queue
//   and then the front stages fill, and full rises.
//   Reset: synchronous; empties every stage and the queue, leaves the check
//   idle with a zero wait count, and loads register defaults (coefficient
//   812, thresholds 0, wait limit 10).
//   Configuration: csr_we writes csr_wdata to register csr_index at an edge;
//   write only while no transfer is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module capacitor_voltage_hysteresis_check (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   output logic                                      full,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]        req_sample_a,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]        req_sample_b,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]        req_sample_c,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]        req_sample_d,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]        req_sample_e,
   output logic                                      empty,
   input  wire logic                                 pop,
   output logic [cvhc_pkg::MV_W-1:0]                 rsp_voltage_mv,
   output logic [1:0]                                rsp_status,
   output logic                                      rsp_power_off,
   input  wire logic                                 csr_we,
   input  wire logic [cvhc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [cvhc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers.
   logic [cvhc_pkg::COEF_W-1:0]  coef_ff, coef_in;
   logic [cvhc_pkg::MV_W-1:0]    low_ff, low_in;
   logic [cvhc_pkg::MV_W-1:0]    high_ff, high_in;
   logic [cvhc_pkg::WAITS_W-1:0] max_waits_ff, max_waits_in;
   cvhc_pkg::hyst_cfg_type       hyst_cfg;

   // Middle queue.
   logic                         q_push, q_pop;
   logic [cvhc_pkg::MV_W-1:0]    q_wdata, q_rdata;
   cvhc_pkg::queue_ctl_type      q_ctl;

   // Decode a register write; an index with no register is dropped.
   always_comb begin
      coef_in      = coef_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      max_waits_in = max_waits_ff;
      if (csr_we) begin
         unique case (csr_index)
            cvhc_pkg::CSR_MEAS_COEF:      coef_in      = csr_wdata[cvhc_pkg::COEF_W-1:0];
            cvhc_pkg::CSR_LOW_THRESHOLD:  low_in       = csr_wdata[cvhc_pkg::MV_W-1:0];
            cvhc_pkg::CSR_HIGH_THRESHOLD: high_in      = csr_wdata[cvhc_pkg::MV_W-1:0];
            cvhc_pkg::CSR_MAX_WAITS:      max_waits_in = csr_wdata[cvhc_pkg::WAITS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= cvhc_pkg::MEAS_COEF_RESET;
         low_ff       <= cvhc_pkg::LOW_RESET;
         high_ff      <= cvhc_pkg::HIGH_RESET;
         max_waits_ff <= cvhc_pkg::MAX_WAITS_RESET;
      end else begin
         coef_ff      <= coef_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         max_waits_ff <= max_waits_in;
      end
   end

   always_comb begin
      hyst_cfg.low_mv    = low_ff;
      hyst_cfg.high_mv   = high_ff;
      hyst_cfg.max_waits = max_waits_ff;
   end

   // Front: median, calibrate, convert to millivolts.
   cvhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .sample_a  (req_sample_a),
      .sample_b  (req_sample_b),
      .sample_c  (req_sample_c),
      .sample_d  (req_sample_d),
      .sample_e  (req_sample_e),
      .meas_coef (coef_ff),
      .q_full    (q_ctl.full),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   // Decouple front and back so each can stall on its own.
   cvhc_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .ctl   (q_ctl),
      .rdata (q_rdata)
   );

   // Back: hysteresis decision and result hold.
   cvhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (hyst_cfg),
      .q_empty    (q_ctl.empty),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .pop        (pop),
      .empty      (empty),
      .voltage_mv (rsp_voltage_mv),
      .status     (rsp_status),
      .power_off  (rsp_power_off)
   );

endmodule

`default_nettype wire

### hdl/cvhc_front.sv
// ----------------------------------------------------------------------------
// cvhc_front
// Median of five, calibration multiply and divide by 500 in three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cvhc_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   output logic                                    full,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]      sample_a,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]      sample_b,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]      sample_c,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]      sample_d,
   input  wire logic [cvhc_pkg::SAMPLE_W-1:0]      sample_e,
   input  wire logic [cvhc_pkg::COEF_W-1:0]        meas_coef,
   input  wire logic                               q_full,
   output logic                                    q_push,
   output logic [cvhc_pkg::MV_W-1:0]               q_wdata
);

   localparam int SW = cvhc_pkg::SAMPLE_W;

   // Returns {min, max}.
   function automatic logic [2*SW-1:0] order_pair(input logic [SW-1:0] x,
                                                  input logic [SW-1:0] y);
      if (x > y) begin
         order_pair = {y, x};
      end else begin
         order_pair = {x, y};
      end
   endfunction

   // Nine-comparator sorting network; the middle element is the median.
   function automatic logic [SW-1:0] median5(input logic [SW-1:0] a,
                                             input logic [SW-1:0] b,
                                             input logic [SW-1:0] c,
                                             input logic [SW-1:0] d,
                                             input logic [SW-1:0] e);
      logic [SW-1:0] v0, v1, v2, v3, v4;
      v0 = a; v1 = b; v2 = c; v3 = d; v4 = e;
      {v0, v3} = order_pair(v0, v3);
      {v1, v4} = order_pair(v1, v4);
      {v0, v2} = order_pair(v0, v2);
      {v1, v3} = order_pair(v1, v3);
      {v0, v1} = order_pair(v0, v1);
      {v2, v4} = order_pair(v2, v4);
      {v1, v2} = order_pair(v1, v2);
      {v3, v4} = order_pair(v3, v4);
      {v2, v3} = order_pair(v2, v3);
      median5 = v2;
   endfunction

   logic                                  s1_valid_ff, s1_valid_in;
   logic                                  s2_valid_ff, s2_valid_in;
   logic                                  s3_valid_ff, s3_valid_in;
   logic [SW-1:0]                         s1_med_ff, s1_med_in;
   logic [cvhc_pkg::PROD_W-1:0]           s2_prod_ff, s2_prod_in;
   logic [cvhc_pkg::DIV_PROD_W-1:0]       s3_quot_ff, s3_quot_in;
   logic                                  s1_adv, s2_adv, s3_adv;

   // Each stage advances when it is empty or the stage after it advances.
   assign s3_adv = !s3_valid_ff || !q_full;
   assign s2_adv = !s2_valid_ff || s3_adv;
   assign s1_adv = !s1_valid_ff || s2_adv;
   assign full   = !s1_adv;

   always_comb begin
      s1_valid_in = s1_adv ? push        : s1_valid_ff;
      s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = s3_adv ? s2_valid_ff : s3_valid_ff;
      s1_med_in   = s1_adv ? median5(sample_a, sample_b, sample_c, sample_d, sample_e)
                           : s1_med_ff;
      s2_prod_in  = s2_adv ? s1_med_ff * meas_coef : s2_prod_ff;
      s3_quot_in  = s3_adv ? s2_prod_ff[cvhc_pkg::PROD_W-1:2] * cvhc_pkg::DIV_RECIP
                           : s3_quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_med_ff  <= s1_med_in;
      s2_prod_ff <= s2_prod_in;
      s3_quot_ff <= s3_quot_in;
   end

   assign q_push  = s3_valid_ff && !q_full;
   assign q_wdata = s3_quot_ff[cvhc_pkg::DIV_SHIFT +: cvhc_pkg::MV_W];

endmodule

`default_nettype wire

### hdl/cvhc_fifo.sv
// ----------------------------------------------------------------------------
// cvhc_fifo
// Short queue of millivolt values between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cvhc_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic [cvhc_pkg::MV_W-1:0]     wdata,
   input  wire logic                          pop,
   output cvhc_pkg::queue_ctl_type            ctl,
   output logic [cvhc_pkg::MV_W-1:0]          rdata
);

   localparam int AW = cvhc_pkg::QUEUE_AW;
   localparam int CW = cvhc_pkg::QUEUE_CW;

   logic [cvhc_pkg::MV_W-1:0] mem_ff [cvhc_pkg::QUEUE_DEPTH];
   logic [AW-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      do_push, do_pop;

   assign ctl.full  = (count_ff == CW'(cvhc_pkg::QUEUE_DEPTH));
   assign ctl.empty = (count_ff == '0);
   assign ctl.push  = push;
   assign ctl.pop   = pop;
   assign do_push   = push && !ctl.full;
   assign do_pop    = pop && !ctl.empty;
   assign rdata     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

### hdl/cvhc_back.sv
// ----------------------------------------------------------------------------
// cvhc_back
// Hysteresis state machine and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cvhc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  cvhc_pkg::hyst_cfg_type             cfg,
   input  wire logic                          q_empty,
   input  wire logic [cvhc_pkg::MV_W-1:0]     q_rdata,
   output logic                               q_pop,
   input  wire logic                          pop,
   output logic                               empty,
   output logic [cvhc_pkg::MV_W-1:0]          voltage_mv,
   output logic [1:0]                         status,
   output logic                               power_off
);

   localparam int WW = cvhc_pkg::WAITS_W;

   cvhc_pkg::hyst_state_type state_ff, state_in, state_nx;
   logic [WW-1:0]            count_ff, count_in, count_nx, count_inc;
   logic                     out_valid_ff, out_valid_in;
   logic [cvhc_pkg::MV_W-1:0] mv_ff;
   cvhc_pkg::status_type     status_ff, status_nx;
   logic                     poff_ff, poff_nx;
   logic                     take, below_low, at_high;

   assign take      = !q_empty && (!out_valid_ff || pop);
   assign q_pop     = take;
   assign below_low = q_rdata < cfg.low_mv;
   assign at_high   = q_rdata >= cfg.high_mv;
   assign count_inc = (count_ff == {WW{1'b1}}) ? count_ff : count_ff + WW'(1);

   // Next state and wait count.
   always_comb begin
      state_nx = state_ff;
      count_nx = count_ff;
      unique case (state_ff)
         cvhc_pkg::HYST_IDLE: begin
            if (below_low) begin
               count_nx = '0;
               if (!at_high && cfg.max_waits != '0) begin
                  state_nx = cvhc_pkg::HYST_WAIT;
               end
            end
         end
         cvhc_pkg::HYST_WAIT: begin
            count_nx = count_inc;
            if (at_high || count_inc >= cfg.max_waits) begin
               state_nx = cvhc_pkg::HYST_IDLE;
            end
         end
         default: begin
            state_nx = cvhc_pkg::HYST_IDLE;
         end
      endcase
      state_in = take ? state_nx : state_ff;
      count_in = take ? count_nx : count_ff;
   end

   // Result of the measurement at the queue head.
   always_comb begin
      status_nx = cvhc_pkg::STATUS_OK;
      poff_nx   = 1'b0;
      unique case (state_ff)
         cvhc_pkg::HYST_IDLE: begin
            if (below_low) begin
               poff_nx = 1'b1;
               priority if (at_high) begin
                  status_nx = cvhc_pkg::STATUS_RECOVERED;
               end else if (cfg.max_waits == '0) begin
                  status_nx = cvhc_pkg::STATUS_TIMEOUT;
               end else begin
                  status_nx = cvhc_pkg::STATUS_WAITING;
               end
            end
         end
         cvhc_pkg::HYST_WAIT: begin
            priority if (at_high) begin
               status_nx = cvhc_pkg::STATUS_RECOVERED;
            end else if (count_inc >= cfg.max_waits) begin
               status_nx = cvhc_pkg::STATUS_TIMEOUT;
            end else begin
               status_nx = cvhc_pkg::STATUS_WAITING;
            end
         end
         default: begin
            status_nx = cvhc_pkg::STATUS_OK;
         end
      endcase
   end

   always_comb begin
      out_valid_in = take ? 1'b1 : (out_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cvhc_pkg::HYST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mv_ff     <= q_rdata;
         status_ff <= status_nx;
         poff_ff   <= poff_nx;
      end
   end

   assign empty      = !out_valid_ff;
   assign voltage_mv = mv_ff;
   assign status     = status_ff;
   assign power_off  = poff_ff;

endmodule

`default_nettype wire

### hdl/cvhc_checker.sv
// ----------------------------------------------------------------------------
// cvhc_checker
// Port-level assertions for the capacitor voltage hysteresis check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "capacitor_voltage_hysteresis_check_macros.svh"

module cvhc_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          pop,
   input  wire logic                          empty,
   input  wire logic [cvhc_pkg::MV_W-1:0]     rsp_voltage_mv,
   input  wire logic [1:0]                    rsp_status,
   input  wire logic                          rsp_power_off
);

   // A measurement that cuts power always reports a nonzero status.
   `CVHC_ASSERT_IMPLIES(a_poff_status, !empty && rsp_power_off, rsp_status != cvhc_pkg::STATUS_OK)

   // The millivolt value never exceeds the largest product over 500.
   `CVHC_ASSERT_IMPLIES(a_mv_range, !empty, rsp_voltage_mv <= cvhc_pkg::VOLTAGE_MAX)

   // Reset flushes every waiting result.
   `CVHC_ASSERT_AFTER_RESET(a_reset_empty, empty)

   // A stalled result stays put.
   `CVHC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(rsp_voltage_mv) && $stable(rsp_status))

endmodule

bind capacitor_voltage_hysteresis_check cvhc_checker u_cvhc_checker (
   .clock          (clock),
   .reset          (reset),
   .pop            (pop),
   .empty          (empty),
   .rsp_voltage_mv (rsp_voltage_mv),
   .rsp_status     (rsp_status),
   .rsp_power_off  (rsp_power_off)
);

`default_nettype wire

### tb/tb_capacitor_voltage_hysteresis_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Capacitor voltage hysteresis check testbench
// Drives five-sample measurements into the input queue and pops results from
// the output queue. Both sides idle and stall at random. A behavioral
// predictor tracks the calibration, the thresholds and the wait state, and
// compares every popped result field by field, in order. Directed tests cover
// the defaults, median corner cases and each way a wait can start and end.
// Random phases then sweep extreme and random register settings.
// ----------------------------------------------------------------------------

module tb_capacitor_voltage_hysteresis_check;
   import cvhc_pkg::*;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 3;
   localparam int CYCLE_LIMIT     = 100000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int MV_DIVISOR      = 500;
   localparam int SAMPLE_MAX      = 4095;

   // One measurement: five raw ADC samples.
   typedef struct packed {
      logic [SAMPLE_W-1:0] a;
      logic [SAMPLE_W-1:0] b;
      logic [SAMPLE_W-1:0] c;
      logic [SAMPLE_W-1:0] d;
      logic [SAMPLE_W-1:0] e;
   } sample_set_type;

   // One result: the millivolt value and the hysteresis verdict.
   typedef struct packed {
      logic [MV_W-1:0] voltage_mv;
      status_type      status;
      logic            power_off;
   } voltage_result_type;

   // ------------------------------------------------------------------------
   // DUT signals; every input starts at a known value.
   // ------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push  = 1'b0;
   logic                   full;
   logic [SAMPLE_W-1:0]    req_sample_a = '0;
   logic [SAMPLE_W-1:0]    req_sample_b = '0;
   logic [SAMPLE_W-1:0]    req_sample_c = '0;
   logic [SAMPLE_W-1:0]    req_sample_d = '0;
   logic [SAMPLE_W-1:0]    req_sample_e = '0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [MV_W-1:0]        rsp_voltage_mv;
   logic [1:0]             rsp_status;
   logic                   rsp_power_off;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MEAS_COEF;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   capacitor_voltage_hysteresis_check dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_sample_a   (req_sample_a),
      .req_sample_b   (req_sample_b),
      .req_sample_c   (req_sample_c),
      .req_sample_d   (req_sample_d),
      .req_sample_e   (req_sample_e),
      .empty          (empty),
      .pop            (pop),
      .rsp_voltage_mv (rsp_voltage_mv),
      .rsp_status     (rsp_status),
      .rsp_power_off  (rsp_power_off),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: a private copy of the registers and the wait tracker.
   // ------------------------------------------------------------------------
   logic [COEF_W-1:0]  coef_shadow  = MEAS_COEF_RESET;
   logic [MV_W-1:0]    low_shadow   = LOW_RESET;
   logic [MV_W-1:0]    high_shadow  = HIGH_RESET;
   logic [WAITS_W-1:0] waits_shadow = MAX_WAITS_RESET;
   hyst_state_type     hyst_shadow  = HYST_IDLE;
   logic [WAITS_W-1:0] count_shadow = '0;

   voltage_result_type pending_results[$];
   int                 error_count = 0;
   int                 cycle_count = 0;

   // Idle odds per cycle, in percent, for each side.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Long receiver hold-off: the test bumps the request count, the pop
   // driver serves it and counts the stretch down on its own.
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Median of five by a plain bubble sort.
   function automatic logic [SAMPLE_W-1:0] median_of(sample_set_type s);
      logic [SAMPLE_W-1:0] v[5];
      logic [SAMPLE_W-1:0] t;
      v[0] = s.a;
      v[1] = s.b;
      v[2] = s.c;
      v[3] = s.d;
      v[4] = s.e;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4 - i; j++) begin
            if (v[j] > v[j + 1]) begin
               t        = v[j];
               v[j]     = v[j + 1];
               v[j + 1] = t;
            end
         end
      end
      return v[2];
   endfunction

   // Work out the result of one transfer and advance the wait tracker.
   function automatic voltage_result_type predict_voltage(sample_set_type s);
      int unsigned        med;
      int unsigned        mv;
      voltage_result_type r;
      med          = median_of(s);
      mv           = (med * coef_shadow) / MV_DIVISOR;
      r.voltage_mv = mv[MV_W-1:0];
      r.status     = STATUS_OK;
      r.power_off  = 1'b0;
      if (hyst_shadow == HYST_IDLE) begin
         if (mv < low_shadow) begin
            // Falling below the low threshold cuts power; the same value
            // may already end the wait before it begins.
            r.power_off  = 1'b1;
            count_shadow = '0;
            if (mv >= high_shadow) begin
               r.status = STATUS_RECOVERED;
            end else if (count_shadow >= waits_shadow) begin
               r.status = STATUS_TIMEOUT;
            end else begin
               r.status    = STATUS_WAITING;
               hyst_shadow = HYST_WAIT;
            end
         end
      end else begin
         if (count_shadow != '1) begin
            count_shadow = count_shadow + 1'b1;
         end
         if (mv >= high_shadow) begin
            r.status    = STATUS_RECOVERED;
            hyst_shadow = HYST_IDLE;
         end else if (count_shadow >= waits_shadow) begin
            r.status    = STATUS_TIMEOUT;
            hyst_shadow = HYST_IDLE;
         end else begin
            r.status = STATUS_WAITING;
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Five samples in random order whose median is exactly m.
   function automatic sample_set_type around_median(int unsigned m);
      logic [SAMPLE_W-1:0] v[5];
      logic [SAMPLE_W-1:0] t;
      int unsigned         k;
      sample_set_type      s;
      v[0] = m;
      v[1] = $urandom_range(m, 0);
      v[2] = $urandom_range(m, 0);
      v[3] = $urandom_range(SAMPLE_MAX, m);
      v[4] = $urandom_range(SAMPLE_MAX, m);
      for (int i = 4; i > 0; i--) begin
         k    = $urandom_range(i, 0);
         t    = v[i];
         v[i] = v[k];
         v[k] = t;
      end
      s.a = v[0];
      s.b = v[1];
      s.c = v[2];
      s.d = v[3];
      s.e = v[4];
      return s;
   endfunction

   // Median sample that lands near a given millivolt value.
   function automatic int unsigned median_near_mv(int unsigned mv);
      int unsigned m;
      if (coef_shadow == 0) begin
         return $urandom_range(SAMPLE_MAX, 0);
      end
      m = (mv * MV_DIVISOR) / coef_shadow;
      return (m > SAMPLE_MAX) ? SAMPLE_MAX : m;
   endfunction

   // Mostly values at or below the low threshold or around the high one, so
   // that waits start, run and end; the rest is raw noise.
   function automatic sample_set_type random_measurement();
      int unsigned    pick;
      int unsigned    lo_med;
      int unsigned    hi_med;
      int unsigned    m;
      sample_set_type s;
      pick   = $urandom_range(99, 0);
      lo_med = median_near_mv(low_shadow);
      hi_med = median_near_mv(high_shadow);
      if (pick < 15) begin
         s.a = $urandom_range(SAMPLE_MAX, 0);
         s.b = $urandom_range(SAMPLE_MAX, 0);
         s.c = $urandom_range(SAMPLE_MAX, 0);
         s.d = $urandom_range(SAMPLE_MAX, 0);
         s.e = $urandom_range(SAMPLE_MAX, 0);
         return s;
      end
      if (pick < 50) begin
         m = $urandom_range(lo_med, 0);
      end else if (pick < 85) begin
         m = $urandom_range((hi_med + 16 > SAMPLE_MAX) ? SAMPLE_MAX : hi_med + 16,
                            (hi_med > 16) ? hi_med - 16 : 0);
      end else begin
         m = $urandom_range(SAMPLE_MAX, 0);
      end
      return around_median(m);
   endfunction

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------

   // Offer one measurement and hold it until the transfer; push stays high
   // afterwards so back-to-back items follow without push dropping.
   task automatic send_measurement(input sample_set_type s);
      if ($urandom_range(99, 0) < send_idle_pct) begin
         push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < send_idle_pct);
      end
      push         <= 1'b1;
      req_sample_a <= s.a;
      req_sample_b <= s.b;
      req_sample_c <= s.c;
      req_sample_d <= s.d;
      req_sample_e <= s.e;
      do @(posedge clock); while (full);
      pending_results.push_back(predict_voltage(s));
   endtask

   // Drop push, wait for every expected result, then let the pipe settle.
   task automatic drain_results();
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0]  value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_MEAS_COEF:      coef_shadow  = value[COEF_W-1:0];
         CSR_LOW_THRESHOLD:  low_shadow   = value[MV_W-1:0];
         CSR_HIGH_THRESHOLD: high_shadow  = value[MV_W-1:0];
         CSR_MAX_WAITS:      waits_shadow = value[WAITS_W-1:0];
         default: ;
      endcase
   endtask

   // Rewrite all four registers; the unused upper data bits carry junk that
   // the block must drop.
   task automatic program_registers(input logic [COEF_W-1:0]  coef,
                                    input logic [MV_W-1:0]    low_mv,
                                    input logic [MV_W-1:0]    high_mv,
                                    input logic [WAITS_W-1:0] waits);
      logic [CSR_DATA_W-COEF_W-1:0]  coef_junk;
      logic [CSR_DATA_W-WAITS_W-1:0] waits_junk;
      coef_junk  = $urandom_range(2 ** (CSR_DATA_W - COEF_W) - 1, 0);
      waits_junk = $urandom_range(2 ** (CSR_DATA_W - WAITS_W) - 1, 0);
      write_register(CSR_MEAS_COEF, {coef_junk, coef});
      write_register(CSR_LOW_THRESHOLD, low_mv);
      write_register(CSR_HIGH_THRESHOLD, high_mv);
      write_register(CSR_MAX_WAITS, {waits_junk, waits});
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Output side
   // ------------------------------------------------------------------------

   // Pop driver: random idling, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_OFF_CYCLES;
         pop          <= 1'b0;
      end else begin
         pop <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Compare every popped result with the oldest expectation.
   always @(posedge clock) begin : result_check
      voltage_result_type want;
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: voltage_mv %0d status %0d power_off %0d",
                     $time, rsp_voltage_mv, rsp_status, rsp_power_off);
         end else begin
            want = pending_results.pop_front();
            if (rsp_voltage_mv !== want.voltage_mv) begin
               error_count++;
               $display("%0t: voltage_mv expected %0d actual %0d",
                        $time, want.voltage_mv, rsp_voltage_mv);
            end
            if (rsp_status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
            end
            if (rsp_power_off !== want.power_off) begin
               error_count++;
               $display("%0t: power_off expected %0d actual %0d",
                        $time, want.power_off, rsp_power_off);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset registers: low threshold 0 never starts a wait. Median corners.
   task automatic test_reset_defaults();
      send_measurement('{a: 0, b: 0, c: 0, d: 0, e: 0});
      send_measurement('{a: 4095, b: 4095, c: 4095, d: 4095, e: 4095});
      send_measurement('{a: 4095, b: 0, c: 2048, d: 1, e: 4094});
      send_measurement('{a: 7, b: 3000, c: 7, d: 3000, e: 2730});
      drain_results();
   endtask

   // Coefficient 500 makes millivolts equal the median. Start a wait, hold
   // it, recover exactly at the high threshold, then sit exactly at low.
   task automatic test_wait_recovery();
      program_registers(12'd500, 16'd1000, 16'd2000, 8'd10);
      send_measurement(around_median(999));
      send_measurement(around_median(1500));
      send_measurement(around_median(2000));
      send_measurement(around_median(1000));
      drain_results();
   endtask

   // Stay low until the wait count reaches the limit, then start again.
   task automatic test_wait_timeout();
      program_registers(12'd500, 16'd1000, 16'd2000, 8'd2);
      repeat (4) send_measurement(around_median(500));
      drain_results();
   endtask

   // A wait that ends on the very measurement that starts it: high below
   // low gives recovery, a zero limit gives timeout.
   task automatic test_immediate_endings();
      program_registers(12'd500, 16'd2000, 16'd1000, 8'd5);
      send_measurement(around_median(1500));
      drain_results();
      program_registers(12'd500, 16'd1000, 16'd2000, 8'd0);
      send_measurement(around_median(10));
      drain_results();
   endtask

   // Lower the limit below the running count in the middle of a wait.
   task automatic test_limit_lowered();
      program_registers(12'd500, 16'd1000, 16'd2000, 8'd10);
      repeat (3) send_measurement(around_median(400));
      drain_results();
      program_registers(12'd500, 16'd1000, 16'd2000, 8'd1);
      send_measurement(around_median(400));
      drain_results();
   endtask

   // Hold the receiver off for a long stretch while the sender keeps
   // offering back to back, so the queue fills and full rises.
   task automatic test_backpressure();
      int saved_send;
      saved_send    = send_idle_pct;
      send_idle_pct = 0;
      program_registers(12'd812, 16'd1500, 16'd2500, 8'd4);
      hold_requests = hold_requests + 1;
      repeat (40) send_measurement(random_measurement());
      drain_results();
      send_idle_pct = saved_send;
   endtask

   task automatic run_random_phase(input int items,
                                   input logic [COEF_W-1:0]  coef,
                                   input logic [MV_W-1:0]    low_mv,
                                   input logic [MV_W-1:0]    high_mv,
                                   input logic [WAITS_W-1:0] waits);
      program_registers(coef, low_mv, high_mv, waits);
      repeat (items) send_measurement(random_measurement());
      drain_results();
   endtask

   // Sweep idle patterns and register settings: typical, all at the top
   // (every wait runs to the 255 limit), all but low at the bottom, and random.
   task automatic test_random_sweep();
      int unsigned lo;
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 49 : 0;
         recv_idle_pct = (mode == 0) ? 49 : (mode == 1) ? 31 : 0;
         run_random_phase(80, 12'd812, 16'd1500, 16'd2500, 8'd10);
         run_random_phase((mode == 2) ? 300 : 100, 12'd4095, 16'hFFFF, 16'hFFFF, 8'hFF);
         run_random_phase(50, 12'd0, 16'hFFFF, 16'd0, 8'd0);
         lo = $urandom_range(30000, 0);
         run_random_phase(90, $urandom_range(4095, 1), lo,
                          $urandom_range(lo + 3000, lo), $urandom_range(20, 0));
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part runs with the first idle pattern.
      send_idle_pct = 31;
      recv_idle_pct = 49;
      test_reset_defaults();
      test_wait_recovery();
      test_wait_timeout();
      test_immediate_endings();
      test_limit_lowered();
      test_backpressure();
      test_random_sweep();

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
